FILE: rtl/lms_parameter_update_unit_defines.svh
// Assertion macros used by the port checker.
`ifndef LMS_PARAMETER_UPDATE_UNIT_DEFINES_SVH
`define LMS_PARAMETER_UPDATE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LPU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/lpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS parameter update package
// Shared types, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package lpu_pkg;
   localparam int PARAM_COUNT_DEF = 128;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int MASS_STRIDE     = 4;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_PHI  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_LEARNING_RATE = 2'd0,
      CSR_MASS_WEIGHT   = 2'd1,
      CSR_THRESHOLD     = 2'd2,
      CSR_IDEAL_MASS    = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_RD_OUT,
      ST_PHI_WAIT,
      ST_PHI_MUL,
      ST_PHI_ACC,
      ST_ROW_END,
      ST_ERR_MUL,
      ST_ERR_SUM,
      ST_UPD_READ,
      ST_UPD_WAIT,
      ST_UPD_P,
      ST_UPD_STEP,
      ST_UPD_WRITE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [6:0]  index;
      logic [31:0] value;
      logic        last;
   } item_type;

   function automatic logic [31:0] sat32(input logic signed [66:0] x);
      logic [31:0] r;
      if (x > 67'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -67'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction
endpackage

FILE: rtl/lpu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/lpu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS front end
// Accepts request beats, drops meaningless ones and queues the rest.
// ----------------------------------------------------------------------------
module lpu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpu_pkg::item_type req_item,
   output logic              q_valid,
   input  logic              q_pop,
   output lpu_pkg::item_type q_item
);
   import lpu_pkg::*;

   item_type   slot_ff [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       push;

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && (req_item.operation != OP_NONE);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + 2'(push) - 2'(q_pop);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end
endmodule

FILE: rtl/lpu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS back end
// Executes loads, reads, phi beats and the row update pass over the stores.
// ----------------------------------------------------------------------------
module lpu_back #(
   parameter int PARAM_COUNT = lpu_pkg::PARAM_COUNT_DEF,
   parameter int FRAC_BITS   = lpu_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  lpu_pkg::item_type q_item,
   input  logic [31:0]       learning_rate,
   input  logic [31:0]       mass_weight,
   input  logic [30:0]       accept_threshold,
   input  logic [30:0]       ideal_mass,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic              rsp_accepted,
   output logic [31:0]       rsp_prediction,
   output logic [31:0]       rsp_mass_sum,
   output logic [31:0]       rsp_read_value
);
   import lpu_pkg::*;

   localparam int AW = $clog2(PARAM_COUNT);
   localparam int PW = AW + 1;

   state_type state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in, upd_ff, upd_in;
   logic signed [63:0] dot_ff, dot_in, mass_ff, mass_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0] err_ff, err_in, beta_ff, beta_in, p_ff, p_in;
   logic        rv_ff, rv_in, kind_ff, kind_in, acc_ff, acc_in;
   logic [31:0] pred_ff, pred_in, msum_ff, msum_in, rval_ff, rval_in;
   logic        last_ff, last_in;
   logic [31:0] phi_ff, phi_in;

   logic          beta_we, row_we;
   logic [AW-1:0] beta_wa, beta_ra, row_wa, row_ra;
   logic [31:0]   beta_wd, beta_rd, row_rd;
   logic [31:0]   mul_a, mul_b;
   logic          mul_a_signed;
   logic signed [65:0] mul_full;
   logic signed [63:0] mul_q;
   logic signed [63:0] mag;
   logic [31:0]   diff, dterm;
   logic          in_range, out_busy;

   lpu_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_beta (
      .clock, .wr_en(beta_we), .wr_addr(beta_wa), .wr_data(beta_wd),
      .rd_addr(beta_ra), .rd_data(beta_rd));
   lpu_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_row (
      .clock, .wr_en(row_we), .wr_addr(row_wa), .wr_data(phi_ff),
      .rd_addr(row_ra), .rd_data(row_rd));

   assign out_busy = rv_ff && !rsp_ready;
   assign in_range = ({25'd0, q_item.index} < 32'(PARAM_COUNT));
   assign mul_full = $signed({mul_a_signed & mul_a[31], mul_a})
                   * $signed({mul_b[31], mul_b});
   assign mul_q    = 64'(mul_full >>> FRAC_BITS);
   assign mag      = dot_ff[63] ? -dot_ff : dot_ff;
   assign diff     = sat32(67'(mass_ff) - 67'($signed({1'b0, ideal_mass})));
   assign dterm    = (upd_ff[1:0] == 2'b00) ?
                     sat32(67'($signed(row_rd)) + 67'($signed({1'b0, mass_weight}))) :
                     row_rd;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_busy) begin
               unique case (q_item.operation)
                  OP_READ: state_in = ST_RD_WAIT;
                  OP_PHI:  state_in = ST_PHI_WAIT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_WAIT:  state_in = ST_RD_OUT;
         ST_RD_OUT:   state_in = ST_IDLE;
         ST_PHI_WAIT: state_in = ST_PHI_MUL;
         ST_PHI_MUL:  state_in = ST_PHI_ACC;
         ST_PHI_ACC:  state_in = last_ff ? ST_ROW_END : ST_IDLE;
         ST_ROW_END:  state_in = (mag > 64'($signed({1'b0, accept_threshold}))) ?
                                 ST_ERR_MUL : ST_RESULT;
         ST_ERR_MUL:  state_in = ST_ERR_SUM;
         ST_ERR_SUM:  state_in = (pos_ff == '0) ? ST_RESULT : ST_UPD_READ;
         ST_UPD_READ: state_in = ST_UPD_WAIT;
         ST_UPD_WAIT: state_in = ST_UPD_P;
         ST_UPD_P:    state_in = ST_UPD_STEP;
         ST_UPD_STEP: state_in = ST_UPD_WRITE;
         ST_UPD_WRITE: state_in = (upd_ff + PW'(1) == pos_ff) ? ST_RESULT : ST_UPD_READ;
         ST_RESULT:   state_in = out_busy ? ST_RESULT : ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0; beta_we = 1'b0; row_we = 1'b0;
      beta_wa = AW'(q_item.index); beta_wd = q_item.value;
      beta_ra = AW'(q_item.index); row_wa = pos_ff[AW-1:0]; row_ra = upd_ff[AW-1:0];
      mul_a = phi_ff; mul_b = beta_rd; mul_a_signed = 1'b1;
      pos_in = pos_ff; upd_in = upd_ff; dot_in = dot_ff; mass_in = mass_ff;
      prod_in = prod_ff; err_in = err_ff; beta_in = beta_ff; p_in = p_ff;
      rv_in = rv_ff && !rsp_ready; kind_in = kind_ff; acc_in = acc_ff;
      pred_in = pred_ff; msum_in = msum_ff; rval_in = rval_ff;
      last_in = last_ff; phi_in = phi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_busy) begin
               q_pop   = 1'b1;
               last_in = q_item.last;
               phi_in  = q_item.value;
               rval_in = in_range ? 32'd0 : 32'd0;
               beta_we = (q_item.operation == OP_LOAD) && in_range;
               if (q_item.operation == OP_PHI) begin
                  beta_ra = pos_ff[AW-1:0];
               end
               kind_in = in_range;
            end
         end
         ST_RD_WAIT: beta_in = beta_rd;
         ST_RD_OUT: begin
            rv_in = 1'b1; acc_in = 1'b0; pred_in = '0; msum_in = '0;
            rval_in = kind_ff ? beta_ff : 32'd0;
            kind_in = 1'b1;
         end
         ST_PHI_WAIT: beta_in = beta_rd;
         ST_PHI_MUL: begin
            mul_a = phi_ff; mul_b = beta_ff;
            if (pos_ff < PW'(PARAM_COUNT)) begin
               prod_in = mul_q;
            end else begin
               prod_in = '0;
            end
         end
         ST_PHI_ACC: begin
            if (pos_ff < PW'(PARAM_COUNT)) begin
               row_we = 1'b1;
               dot_in = dot_ff + prod_ff;
               if (pos_ff[1:0] == 2'b00) mass_in = mass_ff + 64'($signed(beta_ff));
               pos_in = pos_ff + PW'(1);
            end
         end
         ST_ROW_END: begin
            acc_in  = (mag > 64'($signed({1'b0, accept_threshold})));
            pred_in = sat32(67'(dot_ff));
            msum_in = sat32(67'(mass_ff));
            rval_in = '0;
            kind_in = 1'b0;
            upd_in  = '0;
         end
         ST_ERR_MUL: begin
            mul_a = mass_weight; mul_a_signed = 1'b0; mul_b = diff;
            prod_in = mul_q;
         end
         ST_ERR_SUM: err_in = sat32(67'(dot_ff) + 67'($signed(sat32(67'(prod_ff)))));
         ST_UPD_READ: beta_ra = upd_ff[AW-1:0];
         ST_UPD_WAIT: begin
            beta_ra = upd_ff[AW-1:0];
            mul_a = err_ff; mul_b = dterm;
            p_in = sat32(67'(mul_q));
            beta_in = beta_rd;
         end
         ST_UPD_P: begin
            mul_a = learning_rate; mul_a_signed = 1'b0; mul_b = p_ff;
            p_in = sat32(67'(mul_q));
         end
         ST_UPD_STEP: beta_in = sat32(67'($signed(beta_ff)) - 67'($signed(p_ff)));
         ST_UPD_WRITE: begin
            beta_we = 1'b1; beta_wa = upd_ff[AW-1:0]; beta_wd = beta_ff;
            upd_in = upd_ff + PW'(1);
         end
         ST_RESULT: begin
            if (!out_busy) begin
               rv_in = 1'b1;
               dot_in = '0; mass_in = '0; pos_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         pos_ff   <= '0;
         dot_ff   <= '0;
         mass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pos_ff   <= pos_in;
         dot_ff   <= dot_in;
         mass_ff  <= mass_in;
      end
      upd_ff <= upd_in; prod_ff <= prod_in; err_ff <= err_in; beta_ff <= beta_in;
      p_ff <= p_in; kind_ff <= kind_in; acc_ff <= acc_in; pred_ff <= pred_in;
      msum_ff <= msum_in; rval_ff <= rval_in; last_ff <= last_in; phi_ff <= phi_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_prediction = pred_ff;
   assign rsp_mass_sum   = msum_ff;
   assign rsp_read_value = rval_ff;
endmodule

FILE: rtl/lms_parameter_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS parameter update unit
// Q16.16 least-mean-squares update of a stored parameter vector.
// ----------------------------------------------------------------------------
// Every beat but a none beat is held in a two-entry queue before the back end
// takes it. A read passes wait and output states, a phi beat wait, multiply and
// accumulate states; a read's response beat is registered from the output
// state. A row end adds row end and result states and, when the row passes the
// threshold, error multiply and sum states and per element read, wait, p, step
// and write states, one update step per element through the shared multiplier.
// The back end takes no new beat while a response beat waits to be accepted.
module lms_parameter_update_unit #(
   parameter int PARAM_COUNT = lpu_pkg::PARAM_COUNT_DEF,
   parameter int FRAC_BITS   = lpu_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [6:0]  req_index,
   input  logic [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic        rsp_accepted,
   output logic [31:0] rsp_prediction,
   output logic [31:0] rsp_mass_sum,
   output logic [31:0] rsp_read_value
);
   import lpu_pkg::*;

   logic [31:0] lr_ff, mw_ff;
   logic [30:0] thr_ff, im_ff;
   item_type    req_item, q_item;
   logic        q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= 32'd65536000;
         mw_ff  <= '0;
         thr_ff <= '0;
         im_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_LEARNING_RATE: lr_ff  <= csr_data;
            CSR_MASS_WEIGHT:   mw_ff  <= csr_data;
            CSR_THRESHOLD:     thr_ff <= csr_data[30:0];
            CSR_IDEAL_MASS:    im_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_item.operation = op_type'(req_operation);
      req_item.index     = req_index;
      req_item.value     = req_value;
      req_item.last      = req_last;
   end

   lpu_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_item,
      .q_valid, .q_pop, .q_item);

   lpu_back #(.PARAM_COUNT(PARAM_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item,
      .learning_rate(lr_ff), .mass_weight(mw_ff),
      .accept_threshold(thr_ff), .ideal_mass(im_ff),
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_accepted,
      .rsp_prediction, .rsp_mass_sum, .rsp_read_value);
endmodule

FILE: rtl/lpu_checker.sv
`timescale 1ns / 1ps
`include "lms_parameter_update_unit_defines.svh"
// ----------------------------------------------------------------------------
// LMS port checker
// Port-level properties of the update unit, bound to the top level.
// ----------------------------------------------------------------------------
module lpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic        rsp_accepted,
   input logic [31:0] rsp_prediction,
   input logic [31:0] rsp_mass_sum,
   input logic [31:0] rsp_read_value
);
   `LPU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value), "Result beat dropped before acceptance.")
   `LPU_ASSERT_IMPL(a_read_clean, clock, reset, rsp_valid && rsp_kind, !rsp_accepted && rsp_prediction == 32'd0 && rsp_mass_sum == 32'd0, "Read beat carries row fields.")
   `LPU_ASSERT_IMPL(a_row_clean, clock, reset, rsp_valid && !rsp_kind, rsp_read_value == 32'd0, "Row beat carries read data.")
endmodule

bind lms_parameter_update_unit lpu_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_kind, .rsp_accepted,
   .rsp_prediction, .rsp_mass_sum, .rsp_read_value);
